/* sv/multi_channel_task_watchdog_defines.svh */
// ---------------------------------------------------------------------------
// Watchdog supervisor assertion macros
// Concurrent check helpers, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_TASK_WATCHDOG_DEFINES_SVH
`define MULTI_CHANNEL_TASK_WATCHDOG_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge of clk outside reset
`define MCTW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds
`define MCTW_ASSERT_NEVER(lbl, expr, msg) \
    `MCTW_ASSERT(lbl, !(expr), msg)
`else
`define MCTW_ASSERT(lbl, prop, msg)
`define MCTW_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

/* sv/mctw_pkg.sv */
// ---------------------------------------------------------------------------
// Watchdog supervisor package
// Shared types, register indexes, phase codes and reset values.
// ---------------------------------------------------------------------------
package mctw_pkg;

    localparam int MAX_COUNTERS = 4;
    localparam int CNT_W        = 16;
    localparam int HOLD_W       = 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD    = 3'd5;

    // Register reset values
    localparam logic [CNT_W-1:0]  LIMIT_0_RST = 16'd60;
    localparam logic [CNT_W-1:0]  LIMIT_1_RST = 16'd40;
    localparam logic [CNT_W-1:0]  LIMIT_2_RST = 16'd10;
    localparam logic [CNT_W-1:0]  LIMIT_3_RST = 16'd3600;
    localparam logic [HOLD_W-1:0] HOLD_RST    = 8'd10;

    // Command codes
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Phase codes as reported on the result word
    localparam logic [1:0] PHASE_START = 2'd0;
    localparam logic [1:0] PHASE_ARM   = 2'd1;
    localparam logic [1:0] PHASE_RUN   = 2'd2;
    localparam logic [1:0] PHASE_HOLD  = 2'd3;

    typedef struct packed {
        logic                               enable;
        logic [MAX_COUNTERS-1:0][CNT_W-1:0] limit;
        logic [HOLD_W-1:0]                  hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic                    restart;
        logic [1:0]              phase;
        logic [MAX_COUNTERS-1:0] trip_mask;
        logic                    watchdog_kick;
    } result_t;

endpackage

/* sv/multi_channel_task_watchdog.sv */
// ---------------------------------------------------------------------------
// Multi-channel task watchdog supervisor
// Four liveness counters supervised through start, arm, run and hold phases.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream carries one command word: tuser[0] is cmd (0 tick, 1 clear),
//   tdata[1:0] the counter to clear. Every word yields one result word on the
//   master stream: kick, trip mask, phase after the step and restart.
//   Registers are written through cfg_we / cfg_index / cfg_wdata while idle.
// Path: an accepted word is held in the input stage register; its result
//   is registered in the result register when the word moves on, and is
//   then offered on the master stream.
// Throughput: one word per cycle while the receiver takes results; the phase
//   machine and the four counter compare/increment slices finish each step
//   combinationally between the input stage and the result register.
// Reset: counters and hold timer clear, phase is start, registers take
//   their default values; both stream stages come up empty.
// Stall: when the receiver holds tready low the result register keeps its
//   word; the input stage still takes one more word, then tready drops.
// ---------------------------------------------------------------------------
`include "multi_channel_task_watchdog_defines.svh"

module multi_channel_task_watchdog
    import mctw_pkg::*;
#(
    parameter int NUM_COUNTERS = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Command stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [1:0] counter_index, [7:2] zero
    input  logic [0:0]            s_axis_tuser,   // [0] cmd
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata    // [0] watchdog_kick, [4:1] trip_mask,
                                                  // [6:5] phase, [7] restart
);

    cfg_t       cfg;
    result_t    result;
    result_t    out_data_reg;
    logic       out_valid_reg;
    logic       in_valid_reg;
    logic       in_cmd_reg;
    logic [1:0] in_idx_reg;
    logic       advance;

    mctw_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mctw_supervisor #(
        .NUM_COUNTERS (NUM_COUNTERS)
    ) u_supervisor (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .step          (advance),
        .cmd           (in_cmd_reg),
        .counter_index (in_idx_reg),
        .result        (result)
    );

    // Move a word on when the result register is free or being emptied
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input stage: hold the accepted command word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_cmd_reg <= s_axis_tuser[0];
            in_idx_reg <= s_axis_tdata[1:0];
        end
    end

    // Result stage: hold the word until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg.restart, out_data_reg.phase,
                            out_data_reg.trip_mask, out_data_reg.watchdog_kick};

    // Checks on the supervisor outputs and the stream stages
    `MCTW_ASSERT(a_kick_in_run, m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[6:5] == PHASE_RUN || m_axis_tdata[6:5] == PHASE_HOLD, "kick reported outside run")
    `MCTW_ASSERT(a_trip_in_hold, m_axis_tvalid && (m_axis_tdata[4:1] != 4'd0) |-> m_axis_tdata[6:5] == PHASE_HOLD, "trip reported outside hold")
    `MCTW_ASSERT(a_restart_to_arm, m_axis_tvalid && m_axis_tdata[7] |-> m_axis_tdata[6:5] == PHASE_ARM, "restart without return to arm")
    `MCTW_ASSERT_NEVER(a_ready_stall, !s_axis_tready && !(m_axis_tvalid && !m_axis_tready), "input stalled while output free")

endmodule

/* sv/mctw_cfg_regs.sv */
// ---------------------------------------------------------------------------
// Watchdog supervisor configuration registers
// Write-only register file holding enable, trip limits and hold length.
// ---------------------------------------------------------------------------
module mctw_cfg_regs
    import mctw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // Decode writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable     <= 1'b0;
            cfg_reg.limit[0]   <= LIMIT_0_RST;
            cfg_reg.limit[1]   <= LIMIT_1_RST;
            cfg_reg.limit[2]   <= LIMIT_2_RST;
            cfg_reg.limit[3]   <= LIMIT_3_RST;
            cfg_reg.hold_ticks <= HOLD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENABLE:  cfg_reg.enable     <= cfg_wdata[0];
                REG_LIMIT_0: cfg_reg.limit[0]   <= cfg_wdata[CNT_W-1:0];
                REG_LIMIT_1: cfg_reg.limit[1]   <= cfg_wdata[CNT_W-1:0];
                REG_LIMIT_2: cfg_reg.limit[2]   <= cfg_wdata[CNT_W-1:0];
                REG_LIMIT_3: cfg_reg.limit[3]   <= cfg_wdata[CNT_W-1:0];
                REG_HOLD:    cfg_reg.hold_ticks <= cfg_wdata[HOLD_W-1:0];
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/mctw_supervisor.sv */
// ---------------------------------------------------------------------------
// Watchdog supervisor core
// Phase machine, liveness counters and hold timer, updated once per word.
// ---------------------------------------------------------------------------
module mctw_supervisor
    import mctw_pkg::*;
#(
    parameter int NUM_COUNTERS = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       step,
    input  logic       cmd,
    input  logic [1:0] counter_index,
    output result_t    result
);

    typedef enum logic [3:0] {
        ST_START = 4'b0001,
        ST_ARM   = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_HOLD  = 4'b1000
    } phase_t;

    phase_t                             phase_reg, phase_next;
    logic [HOLD_W-1:0]                  hold_reg, hold_next;
    logic [NUM_COUNTERS-1:0][CNT_W-1:0] count_reg, count_next;
    logic [MAX_COUNTERS-1:0]            mask;
    logic                               kick;
    logic                               restart;
    logic [1:0]                         phase_code;

    // Compare every counter against its limit using the old value
    always_comb
    begin
        mask = '0;
        for (int i = 0; i < NUM_COUNTERS; i++)
        begin
            mask[i] = (count_reg[i] > cfg.limit[i]);
        end
    end

    // Work out the next state for the word in the input stage
    always_comb
    begin
        phase_next = phase_reg;
        hold_next  = hold_reg;
        count_next = count_reg;
        kick       = 1'b0;
        restart    = 1'b0;
        if (cmd == CMD_CLEAR)
        begin
            // Clear one counter; absent counters have no slot
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                if (counter_index == 2'(i))
                begin
                    count_next[i] = '0;
                end
            end
        end
        else
        begin
            unique case (phase_reg)
                ST_START:
                begin
                    phase_next = ST_ARM;
                end
                ST_ARM:
                begin
                    if (cfg.enable)
                    begin
                        kick       = 1'b1;
                        count_next = '0;
                        phase_next = ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    kick = cfg.enable;
                    for (int i = 0; i < NUM_COUNTERS; i++)
                    begin
                        count_next[i] = count_reg[i] + 1'b1;
                    end
                    if (|mask)
                    begin
                        phase_next = ST_HOLD;
                        hold_next  = cfg.hold_ticks;
                    end
                end
                ST_HOLD:
                begin
                    if (hold_reg <= HOLD_W'(1))
                    begin
                        hold_next  = '0;
                        phase_next = ST_ARM;
                        restart    = 1'b1;
                    end
                    else
                    begin
                        hold_next = hold_reg - 1'b1;
                    end
                end
                default:
                begin
                    phase_next = ST_START;
                end
            endcase
        end
    end

    // Map the phase after the step to its reported code
    always_comb
    begin
        unique case (phase_next)
            ST_START: phase_code = PHASE_START;
            ST_ARM:   phase_code = PHASE_ARM;
            ST_RUN:   phase_code = PHASE_RUN;
            ST_HOLD:  phase_code = PHASE_HOLD;
            default:  phase_code = PHASE_START;
        endcase
    end

    // Commit the step when the word moves to the output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ST_START;
            hold_reg  <= '0;
            count_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            hold_reg  <= hold_next;
            count_reg <= count_next;
        end
    end

    assign result.watchdog_kick = kick;
    assign result.trip_mask     = (cmd == CMD_TICK && phase_reg == ST_RUN) ? mask : '0;
    assign result.phase         = phase_code;
    assign result.restart       = restart;

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Watchdog supervisor testbench
// Drives command words into the supervisor, predicts every result word from
// its own copy of the phase machine, counters and registers, and checks each
// returned word field by field under several register settings and several
// patterns of sender gaps and receiver stalls.
// ---------------------------------------------------------------------------

// Scoreboard: shadow supervisor plus the queue of result words still due
class watchdog_scoreboard;

    localparam int NUM_CH = mctw_pkg::MAX_COUNTERS;

    // Shadow registers
    bit              sup_enable;
    bit [15:0]       trip_limit [NUM_CH];
    bit [7:0]        hold_len;

    // Shadow state
    bit [15:0]       live_count [NUM_CH];
    bit [1:0]        sup_phase;
    bit [7:0]        hold_left;

    mctw_pkg::result_t expected_words [$];
    int              error_count;

    function new();
        sup_enable    = 1'b0;
        trip_limit[0] = mctw_pkg::LIMIT_0_RST;
        trip_limit[1] = mctw_pkg::LIMIT_1_RST;
        trip_limit[2] = mctw_pkg::LIMIT_2_RST;
        trip_limit[3] = mctw_pkg::LIMIT_3_RST;
        hold_len      = mctw_pkg::HOLD_RST;
        foreach (live_count[i])
            live_count[i] = '0;
        sup_phase   = mctw_pkg::PHASE_START;
        hold_left   = '0;
        error_count = 0;
    endfunction

    // Mirror one register write
    function void set_register(bit [2:0] idx, bit [15:0] value);
        case (idx)
            mctw_pkg::REG_ENABLE:  sup_enable    = value[0];
            mctw_pkg::REG_LIMIT_0: trip_limit[0] = value;
            mctw_pkg::REG_LIMIT_1: trip_limit[1] = value;
            mctw_pkg::REG_LIMIT_2: trip_limit[2] = value;
            mctw_pkg::REG_LIMIT_3: trip_limit[3] = value;
            mctw_pkg::REG_HOLD:    hold_len      = value[7:0];
            default: ;
        endcase
    endfunction

    // Advance the shadow supervisor by one command word
    function mctw_pkg::result_t step_supervisor(bit cmd, bit [1:0] idx);
        mctw_pkg::result_t r;
        r = '0;
        if (cmd == mctw_pkg::CMD_CLEAR) begin
            if (idx < NUM_CH)
                live_count[idx] = '0;
        end
        else begin
            case (sup_phase)
                mctw_pkg::PHASE_START:
                    sup_phase = mctw_pkg::PHASE_ARM;
                mctw_pkg::PHASE_ARM:
                    if (sup_enable)
                    begin
                        r.watchdog_kick = 1'b1;
                        foreach (live_count[i])
                            live_count[i] = '0;
                        sup_phase = mctw_pkg::PHASE_RUN;
                    end
                mctw_pkg::PHASE_RUN:
                begin
                    r.watchdog_kick = sup_enable;
                    // compare on the old value, then bump with wrap
                    for (int i = 0; i < NUM_CH; i++)
                    begin
                        if (live_count[i] > trip_limit[i])
                            r.trip_mask[i] = 1'b1;
                        live_count[i] = live_count[i] + 16'd1;
                    end
                    if (r.trip_mask != '0)
                    begin
                        sup_phase = mctw_pkg::PHASE_HOLD;
                        hold_left = hold_len;
                    end
                end
                default:
                    if (hold_left <= 8'd1)
                    begin
                        hold_left = '0;
                        sup_phase = mctw_pkg::PHASE_ARM;
                        r.restart = 1'b1;
                    end
                    else
                        hold_left = hold_left - 8'd1;
            endcase
        end
        r.phase = sup_phase;
        return r;
    endfunction

    // Note an accepted command word
    function void note_command(bit cmd, bit [1:0] idx);
        expected_words.push_back(step_supervisor(cmd, idx));
    endfunction

    // Check a returned result word against the oldest prediction
    function void check_result(logic [7:0] word);
        mctw_pkg::result_t want;
        mctw_pkg::result_t got;
        got = mctw_pkg::result_t'(word);
        if (expected_words.size() == 0)
        begin
            $display("%0t: unexpected result word, expected none, actual %h", $time, word);
            error_count++;
            return;
        end
        want = expected_words.pop_front();
        if (got.watchdog_kick !== want.watchdog_kick)
        begin
            $display("%0t: watchdog_kick mismatch, expected %b, actual %b",
                     $time, want.watchdog_kick, got.watchdog_kick);
            error_count++;
        end
        if (got.trip_mask !== want.trip_mask)
        begin
            $display("%0t: trip_mask mismatch, expected %b, actual %b",
                     $time, want.trip_mask, got.trip_mask);
            error_count++;
        end
        if (got.phase !== want.phase)
        begin
            $display("%0t: phase mismatch, expected %0d, actual %0d",
                     $time, want.phase, got.phase);
            error_count++;
        end
        if (got.restart !== want.restart)
        begin
            $display("%0t: restart mismatch, expected %b, actual %b",
                     $time, want.restart, got.restart);
            error_count++;
        end
    endfunction

    // Flag predictions that never got a result word
    function void report_leftovers();
        if (expected_words.size() != 0)
        begin
            $display("%0t: %0d result words missing, expected %h, actual none",
                     $time, expected_words.size(), expected_words[0]);
            error_count++;
        end
    endfunction

endclass

module testbench;

    import mctw_pkg::*;

    localparam int HOLDOFF_CYCLES = 64;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;   // [1:0] counter_index, [7:2] zero
    logic [0:0]            s_axis_tuser  = '0;   // [0] cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;         // [0] kick, [4:1] trip_mask,
                                                 // [6:5] phase, [7] restart

    watchdog_scoreboard sb = new();

    int sender_gap_pct   = 0;
    int receiver_gap_pct = 0;
    bit holdoff_request  = 1'b0;

    multi_channel_task_watchdog dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Give up on a hung run
    initial
    begin
        #5_000_000;
        $display("testbench failed");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (holdoff_request)
            begin
                holdoff_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge clk);
            end
            m_axis_tready <= !(receiver_gap_pct > 0 &&
                               $urandom_range(99) < receiver_gap_pct);
        end
    end

    // Watch both handshakes; check results before noting new words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_command(s_axis_tuser[0], s_axis_tdata[1:0]);
        end
    end

    // Select the gap pattern of both sides
    task automatic set_idle_mode(input int mode);
        case (mode)
            1:       begin sender_gap_pct = 82; receiver_gap_pct = 0;  end
            2:       begin sender_gap_pct = 0;  receiver_gap_pct = 82; end
            3:       begin sender_gap_pct = 15; receiver_gap_pct = 15; end
            default: begin sender_gap_pct = 0;  receiver_gap_pct = 0;  end
        endcase
    endtask

    // Write one register; called only while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        sb.set_register(idx, value);
        @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Offer one command word and hold it until accepted
    task automatic send_command(input logic cmd, input logic [1:0] idx);
        while (sender_gap_pct > 0 && $urandom_range(99) < sender_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {6'b0, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Stop sending and wait for every outstanding result word
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_words.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Mostly small limits, with the extremes and full-range values mixed in
    function automatic logic [15:0] pick_limit();
        case ($urandom_range(9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(12));
        endcase
    endfunction

    function automatic logic [7:0] pick_hold();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'($urandom);
            default: return 8'($urandom_range(4, 1));
        endcase
    endfunction

    // Main sequence
    initial
    begin
        int tick_pct;
        int n_items;
        logic [7:0] hold_val;

        // Hold reset, then release it on a falling edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: clear in start, tick out of start, idle arm while disabled
        set_idle_mode(0);
        send_command(CMD_CLEAR, 2'd0);
        send_command(CMD_TICK,  2'd0);
        send_command(CMD_TICK,  2'd3);
        send_command(CMD_CLEAR, 2'd1);
        send_command(CMD_CLEAR, 2'd2);
        send_command(CMD_CLEAR, 2'd3);
        drain_results();

        // Directed: tight limits, zero hold length, trip and restart
        write_reg(REG_ENABLE,  16'hFFFF);
        write_reg(REG_LIMIT_0, 16'd0);
        write_reg(REG_LIMIT_1, 16'd1);
        write_reg(REG_LIMIT_2, 16'd2);
        write_reg(REG_LIMIT_3, 16'hFFFF);
        write_reg(REG_HOLD,    16'hFF00);
        send_command(CMD_TICK,  2'd0);
        send_command(CMD_TICK,  2'd1);
        send_command(CMD_CLEAR, 2'd0);
        send_command(CMD_TICK,  2'd2);
        send_command(CMD_CLEAR, 2'd1);
        send_command(CMD_CLEAR, 2'd2);
        send_command(CMD_TICK,  2'd0);
        send_command(CMD_TICK,  2'd0);
        drain_results();

        // Directed: arm while disabled, then run while disabled
        write_reg(REG_ENABLE, 16'hFFFE);
        write_reg(REG_HOLD,   16'd1);
        send_command(CMD_TICK, 2'd0);
        drain_results();
        write_reg(REG_ENABLE, 16'd1);
        send_command(CMD_TICK, 2'd0);
        send_command(CMD_TICK, 2'd0);
        drain_results();
        write_reg(REG_ENABLE, 16'd0);
        send_command(CMD_TICK,  2'd0);
        send_command(CMD_CLEAR, 2'd3);
        send_command(CMD_TICK,  2'd0);
        drain_results();

        // Steady run of ticks with high limits: kick on every tick, no trip
        write_reg(REG_ENABLE,  16'd1);
        write_reg(REG_LIMIT_0, 16'hFFFE);
        write_reg(REG_LIMIT_1, 16'hFFFF);
        write_reg(REG_LIMIT_2, 16'hFFFF);
        write_reg(REG_LIMIT_3, 16'hFFFF);
        write_reg(REG_HOLD,    16'd3);
        repeat (50) send_command(CMD_TICK, 2'($urandom));
        drain_results();

        // Random phases: fresh registers and gap pattern for each
        for (int p = 0; p < 10; p++)
        begin
            hold_val = pick_hold();
            tick_pct = $urandom_range(75, 45);
            n_items  = 120;
            if (p == 5)
            begin
                // long hold: mostly ticks so the hold can run out
                hold_val = 8'd255;
                tick_pct = 90;
                n_items  = 400;
            end
            write_reg(REG_ENABLE,  {15'($urandom), ($urandom_range(9) < 8)});
            write_reg(REG_LIMIT_0, pick_limit());
            write_reg(REG_LIMIT_1, pick_limit());
            write_reg(REG_LIMIT_2, pick_limit());
            write_reg(REG_LIMIT_3, pick_limit());
            write_reg(REG_HOLD,    {8'($urandom), hold_val});
            set_idle_mode(p % 4);

            // Fill the block against a stalled receiver once
            if (p == 4)
                holdoff_request = 1'b1;

            for (int k = 0; k < n_items; k++)
            begin
                if ($urandom_range(99) < tick_pct)
                    send_command(CMD_TICK, 2'($urandom));
                else
                    send_command(CMD_CLEAR, 2'($urandom));
                // pause for all results once in the middle of a phase
                if (k == n_items / 2 && p == 7)
                    drain_results();
            end
            drain_results();
        end

        // Wrap up
        set_idle_mode(0);
        drain_results();
        repeat (10) @(negedge clk);
        sb.report_leftovers();
        if (sb.error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/mctw_pkg.sv
sv/mctw_cfg_regs.sv
sv/mctw_supervisor.sv
sv/multi_channel_task_watchdog.sv
test/testbench.sv
